// ----- sv/first_fit_heap_allocator_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the first-fit heap allocator
// Short forms for the concurrent checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_CORE_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define FFHA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent on the next edge.
`define FFHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ffha_pkg.sv -----
// ---------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator.
// ---------------------------------------------------------------------------
package ffha_pkg;

    localparam int MAX_FREE_SEGMENTS = 64;
    localparam int MAX_LIVE_BLOCKS   = 64;
    localparam int ADDR_WIDTH        = 32;

    localparam int SEG_IDX_W  = $clog2(MAX_FREE_SEGMENTS);
    localparam int SEG_CNT_W  = $clog2(MAX_FREE_SEGMENTS + 1);
    localparam int LIVE_IDX_W = (MAX_LIVE_BLOCKS > 1) ? $clog2(MAX_LIVE_BLOCKS) : 1;
    localparam int LIVE_CNT_W = $clog2(MAX_LIVE_BLOCKS + 1);
    localparam int ALU_W      = ADDR_WIDTH + 1;

    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 32;
    localparam int MIN_SPLIT_W = 21;
    localparam int HEADER_W    = 8;

    localparam logic [31:0] HEAP_BASE_RST  = 32'h0060_0000;
    localparam logic [31:0] HEAP_LIMIT_RST = 32'h0860_0000;
    localparam logic [MIN_SPLIT_W-1:0] MIN_SPLIT_RST = MIN_SPLIT_W'(4096);
    localparam logic [HEADER_W-1:0]    HEADER_RST    = HEADER_W'(16);

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPLIT  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER     = CFG_IDX_W'(3);

    typedef enum logic [2:0] {
        STAT_OK      = 3'd0,
        STAT_ZERO    = 3'd1,
        STAT_FEW     = 3'd2,
        STAT_NOFIT   = 3'd3,
        STAT_IGNORED = 3'd4,
        STAT_FULL    = 3'd5
    } status_t;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W:0] res;  // top bit is the borrow on a subtract
    } alu_rsp_t;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] start;
        logic [ADDR_WIDTH-1:0] size;
    } entry_t;

    typedef struct packed {
        logic        action;
        logic [31:0] request_size;
        logic [31:0] free_address;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] block_address;
        logic [31:0] free_bytes;
        logic [6:0]  free_segments;
        logic [15:0] alloc_count;
        logic [15:0] free_count;
    } out_t;

endpackage

// ----- sv/ffha_ram.sv -----
// ---------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/ffha_alu.sv -----
// ---------------------------------------------------------------------------
// ffha_alu
// Shared add/subtract unit; the address and size sums and subtract compares of the allocator use it.
// ---------------------------------------------------------------------------
module ffha_alu (
    input  ffha_pkg::alu_req_t req,
    output ffha_pkg::alu_rsp_t rsp
);

    always_comb begin
        case (req.op)
            ffha_pkg::ALU_ADD: rsp.res = {1'b0, req.a} + {1'b0, req.b};
            ffha_pkg::ALU_SUB: rsp.res = {1'b0, req.a} - {1'b0, req.b};
            default:           rsp.res = '0;
        endcase
    end

endmodule

// ----- sv/first_fit_heap_allocator_core.sv -----
// ---------------------------------------------------------------------------
// first_fit_heap_allocator_core
// First-fit allocator over an address-sorted free table with coalescing.
// ---------------------------------------------------------------------------
//  channel   direction  ports                        beat
//  s_        in         s_valid s_ready s_data       one allocate or free
//  m_        out        m_valid m_ready m_data       one result
//  cfg_      in         cfg_valid cfg_ready cfg_*    one register write
//
//  A free walks the live table for the matching block, then the free table
//  up to the insert point, and then either shifts the entries past it up to
//  insert a new one, rewrites a neighbour it joins, or, when it joins both,
//  removes the next entry by shifting the rest down. An allocate walks the
//  free table for the first fit, then the live valid bits for an idle slot,
//  and either writes the split remainder in place or removes the entry by
//  shifting the rest. s_ready is high only while the sequencer idles.
//  A finished result sits in the output register while the next beat is
//  taken; the sequencer stalls in its last step only if that register is full.
//  Reset is synchronous, active low; no clearing pass is run.
// ---------------------------------------------------------------------------
`include "first_fit_heap_allocator_core_macros.svh"

module first_fit_heap_allocator_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  ffha_pkg::in_t                      s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output ffha_pkg::out_t                     m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ffha_pkg::CFG_DATA_W-1:0]    cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_A_CHECK, S_SETUP, S_NEED, S_FEW, S_SCAN_RD, S_SCAN_CHK, S_SLOT,
        S_REST, S_SPLIT, S_SPLITADDR, S_RM_RD, S_RM_WR, S_ACCT_A, S_ADDR,
        S_F_CHECK, S_F_LRD, S_F_LCHK, S_F_PRD, S_F_PCHK, S_F_JOIN, S_F_JOIN2,
        S_F_ACT, S_F_BOTH, S_INS_RD, S_INS_WR, S_F_ACCT, S_FINISH
    } state_t;

    localparam int AW  = ffha_pkg::ADDR_WIDTH;
    localparam int SCW = ffha_pkg::SEG_CNT_W;
    localparam int SIW = ffha_pkg::SEG_IDX_W;
    localparam int LCW = ffha_pkg::LIVE_CNT_W;
    localparam int LIW = ffha_pkg::LIVE_IDX_W;
    localparam int XW  = ffha_pkg::ALU_W;

    state_t state_reg;

    // configuration
    logic [31:0]                         heap_base_reg;
    logic [31:0]                         heap_limit_reg;
    logic [ffha_pkg::MIN_SPLIT_W-1:0]    min_split_reg;
    logic [ffha_pkg::HEADER_W-1:0]       header_reg;

    // heap bookkeeping
    logic [SCW-1:0]                      seg_count_reg;
    logic [ffha_pkg::MAX_LIVE_BLOCKS-1:0] live_valid_reg;
    logic [AW-1:0]                       bytes_left_reg;
    logic [15:0]                         allocs_reg;
    logic [15:0]                         frees_reg;
    logic                                heap_ready_reg;

    // per-beat working registers
    logic                                act_reg;
    logic [31:0]                         req_reg;
    logic [31:0]                         faddr_reg;
    logic [XW-1:0]                       need_reg;
    logic [SCW-1:0]                      idx_reg;
    logic [SCW-1:0]                      k_reg;
    logic [LCW-1:0]                      slot_reg;
    ffha_pkg::entry_t                    cur_reg;
    ffha_pkg::entry_t                    prev_reg;
    logic [AW-1:0]                       rest_reg;
    logic [AW-1:0]                       blk_size_reg;
    logic [AW-1:0]                       acc_reg;
    logic                                wp_reg;
    logic                                wn_reg;
    ffha_pkg::status_t                   status_reg;
    logic [31:0]                         addr_reg;

    logic                                m_valid_reg;
    ffha_pkg::out_t                      m_data_reg;

    // shared unit and memories
    ffha_pkg::alu_req_t                  alu_req;
    ffha_pkg::alu_rsp_t                  alu_rsp;
    logic                                borrow;
    logic [AW-1:0]                       alu_lo;

    logic                                seg_we;
    logic [SIW-1:0]                      seg_waddr;
    ffha_pkg::entry_t                    seg_wdata;
    logic [SCW-1:0]                      seg_rsel;
    ffha_pkg::entry_t                    seg_rdata;

    logic                                live_we;
    ffha_pkg::entry_t                    live_wdata;
    ffha_pkg::entry_t                    live_rdata;

    logic                                split_go;
    logic [SCW-1:0]                      idx_m1;

    ffha_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign borrow  = alu_rsp.res[XW];
    assign alu_lo  = alu_rsp.res[AW-1:0];
    assign idx_m1  = idx_reg - SCW'(1);
    assign split_go = borrow;  // min_split - rest borrows when rest is larger

    ffha_ram #(
        .WIDTH ($bits(ffha_pkg::entry_t)),
        .DEPTH (ffha_pkg::MAX_FREE_SEGMENTS)
    ) u_seg_ram (
        .aclk  (aclk),
        .we    (seg_we),
        .waddr (seg_waddr),
        .wdata (seg_wdata),
        .raddr (seg_rsel[SIW-1:0]),
        .rdata (seg_rdata)
    );

    ffha_ram #(
        .WIDTH ($bits(ffha_pkg::entry_t)),
        .DEPTH (ffha_pkg::MAX_LIVE_BLOCKS)
    ) u_live_ram (
        .aclk  (aclk),
        .we    (live_we),
        .waddr (slot_reg[LIW-1:0]),
        .wdata (live_wdata),
        .raddr (slot_reg[LIW-1:0]),
        .rdata (live_rdata)
    );

    // Route operands to the shared adder and drive the table ports.
    always_comb begin
        alu_req    = '{op: ffha_pkg::ALU_ADD, a: '0, b: '0};
        seg_we     = 1'b0;
        seg_waddr  = idx_reg[SIW-1:0];
        seg_wdata  = '0;
        seg_rsel   = idx_reg;
        live_we    = 1'b0;
        live_wdata = '0;
        case (state_reg)
            S_SETUP: begin
                alu_req   = '{op: ffha_pkg::ALU_SUB, a: XW'(heap_limit_reg),
                              b: XW'(heap_base_reg)};
                seg_we    = !borrow && (alu_lo != '0);
                seg_waddr = '0;
                seg_wdata = '{start: heap_base_reg, size: alu_lo};
            end
            S_NEED: begin
                alu_req = '{op: ffha_pkg::ALU_ADD, a: XW'(req_reg), b: XW'(header_reg)};
            end
            S_FEW: begin
                alu_req = '{op: ffha_pkg::ALU_SUB, a: XW'(bytes_left_reg), b: need_reg};
            end
            S_SCAN_CHK: begin
                alu_req = '{op: ffha_pkg::ALU_SUB, a: XW'(seg_rdata.size), b: need_reg};
            end
            S_REST: begin
                alu_req = '{op: ffha_pkg::ALU_SUB, a: XW'(cur_reg.size), b: need_reg};
            end
            S_SPLIT: begin
                alu_req    = '{op: ffha_pkg::ALU_SUB, a: XW'(min_split_reg),
                               b: XW'(rest_reg)};
                live_we    = 1'b1;
                live_wdata = '{start: cur_reg.start,
                               size:  split_go ? need_reg[AW-1:0] : cur_reg.size};
            end
            S_SPLITADDR: begin
                alu_req   = '{op: ffha_pkg::ALU_ADD, a: XW'(cur_reg.start), b: need_reg};
                seg_we    = 1'b1;
                seg_wdata = '{start: alu_lo, size: rest_reg};
            end
            S_RM_RD: begin
                seg_rsel = k_reg + SCW'(1);
            end
            S_RM_WR: begin
                seg_we    = 1'b1;
                seg_waddr = k_reg[SIW-1:0];
                seg_wdata = seg_rdata;
            end
            S_ACCT_A: begin
                alu_req = '{op: ffha_pkg::ALU_SUB, a: XW'(bytes_left_reg),
                            b: XW'(blk_size_reg)};
            end
            S_ADDR: begin
                alu_req = '{op: ffha_pkg::ALU_ADD, a: XW'(cur_reg.start), b: XW'(header_reg)};
            end
            S_F_LCHK: begin
                alu_req = '{op: ffha_pkg::ALU_ADD, a: XW'(live_rdata.start),
                            b: XW'(header_reg)};
            end
            S_F_PCHK: begin
                alu_req = '{op: ffha_pkg::ALU_SUB, a: XW'(acc_reg),
                            b: XW'(seg_rdata.start)};
            end
            S_F_JOIN: begin
                alu_req = '{op: ffha_pkg::ALU_ADD, a: XW'(prev_reg.start),
                            b: XW'(prev_reg.size)};
            end
            S_F_JOIN2: begin
                alu_req = '{op: ffha_pkg::ALU_ADD, a: XW'(acc_reg), b: XW'(blk_size_reg)};
            end
            S_F_ACT: begin
                if (wp_reg) begin
                    alu_req   = '{op: ffha_pkg::ALU_ADD, a: XW'(prev_reg.size),
                                  b: XW'(blk_size_reg)};
                    seg_we    = !wn_reg;
                    seg_waddr = idx_m1[SIW-1:0];
                    seg_wdata = '{start: prev_reg.start, size: alu_lo};
                end else if (wn_reg) begin
                    alu_req   = '{op: ffha_pkg::ALU_ADD, a: XW'(cur_reg.size),
                                  b: XW'(blk_size_reg)};
                    seg_we    = 1'b1;
                    seg_wdata = '{start: acc_reg, size: alu_lo};
                end
            end
            S_F_BOTH: begin
                alu_req   = '{op: ffha_pkg::ALU_ADD, a: XW'(rest_reg), b: XW'(cur_reg.size)};
                seg_we    = 1'b1;
                seg_waddr = idx_m1[SIW-1:0];
                seg_wdata = '{start: prev_reg.start, size: alu_lo};
            end
            S_INS_RD: begin
                seg_rsel  = k_reg - SCW'(1);
                seg_we    = (k_reg == idx_reg);
                seg_wdata = '{start: acc_reg, size: blk_size_reg};
            end
            S_INS_WR: begin
                seg_we    = 1'b1;
                seg_waddr = k_reg[SIW-1:0];
                seg_wdata = seg_rdata;
            end
            S_F_ACCT: begin
                alu_req = '{op: ffha_pkg::ALU_ADD, a: XW'(bytes_left_reg),
                            b: XW'(blk_size_reg)};
            end
            default: begin
                alu_req = '{op: ffha_pkg::ALU_ADD, a: '0, b: '0};
            end
        endcase
    end

    // Sequencer, bookkeeping and output register.
    // In the free path acc_reg holds the block start and blk_size_reg its size.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            heap_base_reg  <= ffha_pkg::HEAP_BASE_RST;
            heap_limit_reg <= ffha_pkg::HEAP_LIMIT_RST;
            min_split_reg  <= ffha_pkg::MIN_SPLIT_RST;
            header_reg     <= ffha_pkg::HEADER_RST;
            seg_count_reg  <= '0;
            live_valid_reg <= '0;
            bytes_left_reg <= '0;
            allocs_reg     <= '0;
            frees_reg      <= '0;
            heap_ready_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    ffha_pkg::CFG_HEAP_BASE:  heap_base_reg  <= cfg_data;
                    ffha_pkg::CFG_HEAP_LIMIT: heap_limit_reg <= cfg_data;
                    ffha_pkg::CFG_MIN_SPLIT:
                        min_split_reg <= cfg_data[ffha_pkg::MIN_SPLIT_W-1:0];
                    ffha_pkg::CFG_HEADER:     header_reg <= cfg_data[ffha_pkg::HEADER_W-1:0];
                    default: ;
                endcase
            end

            // Drop a taken result; the final step reloads the register itself.
            if (m_valid_reg && m_ready && state_reg != S_FINISH) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        act_reg   <= s_data.action;
                        req_reg   <= s_data.request_size;
                        faddr_reg <= s_data.free_address;
                        addr_reg  <= '0;
                        state_reg <= (s_data.action == ffha_pkg::ACT_FREE) ?
                                     S_F_CHECK : S_A_CHECK;
                    end
                end
                S_A_CHECK: begin
                    if (req_reg == '0) begin
                        status_reg <= ffha_pkg::STAT_ZERO;
                        state_reg  <= S_FINISH;
                    end else begin
                        state_reg  <= heap_ready_reg ? S_NEED : S_SETUP;
                    end
                end
                S_SETUP: begin
                    heap_ready_reg <= 1'b1;
                    if (!borrow && alu_lo != '0) begin
                        seg_count_reg  <= SCW'(1);
                        bytes_left_reg <= alu_lo;
                    end else begin
                        seg_count_reg  <= '0;
                        bytes_left_reg <= '0;
                    end
                    state_reg <= S_NEED;
                end
                S_NEED: begin
                    need_reg  <= alu_rsp.res[XW-1:0];
                    state_reg <= S_FEW;
                end
                S_FEW: begin
                    idx_reg <= '0;
                    if (borrow) begin
                        status_reg <= ffha_pkg::STAT_FEW;
                        state_reg  <= S_FINISH;
                    end else begin
                        state_reg  <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: begin
                    if (idx_reg >= seg_count_reg) begin
                        status_reg <= ffha_pkg::STAT_NOFIT;
                        state_reg  <= S_FINISH;
                    end else begin
                        state_reg  <= S_SCAN_CHK;
                    end
                end
                S_SCAN_CHK: begin
                    if (!borrow) begin
                        cur_reg   <= seg_rdata;
                        slot_reg  <= '0;
                        state_reg <= S_SLOT;
                    end else begin
                        idx_reg   <= idx_reg + SCW'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_SLOT: begin
                    if (slot_reg == LCW'(ffha_pkg::MAX_LIVE_BLOCKS)) begin
                        status_reg <= ffha_pkg::STAT_FULL;
                        state_reg  <= S_FINISH;
                    end else if (!live_valid_reg[slot_reg[LIW-1:0]]) begin
                        state_reg  <= S_REST;
                    end else begin
                        slot_reg   <= slot_reg + LCW'(1);
                    end
                end
                S_REST: begin
                    rest_reg  <= alu_lo;
                    state_reg <= S_SPLIT;
                end
                S_SPLIT: begin
                    live_valid_reg[slot_reg[LIW-1:0]] <= 1'b1;
                    blk_size_reg <= split_go ? need_reg[AW-1:0] : cur_reg.size;
                    k_reg        <= idx_reg;
                    state_reg    <= split_go ? S_SPLITADDR : S_RM_RD;
                end
                S_SPLITADDR: begin
                    state_reg <= S_ACCT_A;
                end
                S_RM_RD: begin
                    if (k_reg + SCW'(1) >= seg_count_reg) begin
                        seg_count_reg <= seg_count_reg - SCW'(1);
                        state_reg     <= (act_reg == ffha_pkg::ACT_FREE) ?
                                         S_F_ACCT : S_ACCT_A;
                    end else begin
                        state_reg <= S_RM_WR;
                    end
                end
                S_RM_WR: begin
                    k_reg     <= k_reg + SCW'(1);
                    state_reg <= S_RM_RD;
                end
                S_ACCT_A: begin
                    bytes_left_reg <= alu_lo;
                    allocs_reg     <= allocs_reg + 16'd1;
                    state_reg      <= S_ADDR;
                end
                S_ADDR: begin
                    addr_reg   <= alu_lo;
                    status_reg <= ffha_pkg::STAT_OK;
                    state_reg  <= S_FINISH;
                end

                S_F_CHECK: begin
                    slot_reg <= '0;
                    if (faddr_reg == '0) begin
                        status_reg <= ffha_pkg::STAT_IGNORED;
                        state_reg  <= S_FINISH;
                    end else begin
                        state_reg  <= S_F_LRD;
                    end
                end
                S_F_LRD: begin
                    if (slot_reg == LCW'(ffha_pkg::MAX_LIVE_BLOCKS)) begin
                        status_reg <= ffha_pkg::STAT_IGNORED;
                        state_reg  <= S_FINISH;
                    end else if (live_valid_reg[slot_reg[LIW-1:0]]) begin
                        state_reg  <= S_F_LCHK;
                    end else begin
                        slot_reg   <= slot_reg + LCW'(1);
                    end
                end
                S_F_LCHK: begin
                    if (alu_lo == faddr_reg) begin
                        acc_reg      <= live_rdata.start;
                        blk_size_reg <= live_rdata.size;
                        idx_reg      <= '0;
                        state_reg    <= S_F_PRD;
                    end else begin
                        slot_reg  <= slot_reg + LCW'(1);
                        state_reg <= S_F_LRD;
                    end
                end
                S_F_PRD: begin
                    state_reg <= (idx_reg >= seg_count_reg) ? S_F_JOIN : S_F_PCHK;
                end
                S_F_PCHK: begin
                    if (borrow) begin
                        cur_reg   <= seg_rdata;
                        state_reg <= S_F_JOIN;
                    end else begin
                        prev_reg  <= seg_rdata;
                        idx_reg   <= idx_reg + SCW'(1);
                        state_reg <= S_F_PRD;
                    end
                end
                S_F_JOIN: begin
                    wp_reg    <= (idx_reg != '0) && (alu_rsp.res[XW-1:0] == XW'(acc_reg));
                    state_reg <= S_F_JOIN2;
                end
                S_F_JOIN2: begin
                    wn_reg    <= (idx_reg < seg_count_reg) &&
                                 (alu_rsp.res[XW-1:0] == XW'(cur_reg.start));
                    state_reg <= S_F_ACT;
                end
                S_F_ACT: begin
                    if (!wp_reg && !wn_reg &&
                        seg_count_reg >= SCW'(ffha_pkg::MAX_FREE_SEGMENTS)) begin
                        status_reg <= ffha_pkg::STAT_FULL;
                        state_reg  <= S_FINISH;
                    end else if (wp_reg && wn_reg) begin
                        rest_reg  <= alu_lo;
                        state_reg <= S_F_BOTH;
                    end else if (wp_reg || wn_reg) begin
                        state_reg <= S_F_ACCT;
                    end else begin
                        k_reg     <= seg_count_reg;
                        state_reg <= S_INS_RD;
                    end
                end
                S_F_BOTH: begin
                    k_reg     <= idx_reg;
                    state_reg <= S_RM_RD;
                end
                S_INS_RD: begin
                    if (k_reg == idx_reg) begin
                        seg_count_reg <= seg_count_reg + SCW'(1);
                        state_reg     <= S_F_ACCT;
                    end else begin
                        state_reg     <= S_INS_WR;
                    end
                end
                S_INS_WR: begin
                    k_reg     <= k_reg - SCW'(1);
                    state_reg <= S_INS_RD;
                end
                S_F_ACCT: begin
                    live_valid_reg[slot_reg[LIW-1:0]] <= 1'b0;
                    bytes_left_reg <= alu_lo;
                    frees_reg      <= frees_reg + 16'd1;
                    status_reg     <= ffha_pkg::STAT_OK;
                    state_reg      <= S_FINISH;
                end

                S_FINISH: begin
                    // Load the result once the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '{status:        status_reg,
                                         block_address: addr_reg,
                                         free_bytes:    bytes_left_reg,
                                         free_segments: 7'(seg_count_reg),
                                         alloc_count:   allocs_reg,
                                         free_count:    frees_reg};
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    `FFHA_ASSERT_ALWAYS(a_seg_count_bound, aclk, aresetn, seg_count_reg <= SCW'(ffha_pkg::MAX_FREE_SEGMENTS), "free table count out of range")
    `FFHA_ASSERT_NEXT(a_result_from_finish, aclk, aresetn, !m_valid_reg && state_reg != S_FINISH, !m_valid_reg, "result raised outside the final step")
    `FFHA_ASSERT_NEXT(a_heap_stays_ready, aclk, aresetn, heap_ready_reg, heap_ready_reg, "heap set-up flag dropped")

endmodule
